// ===== rtl/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranging unit.
// No dependencies; imported by uer_dist_conv and ultrasonic_echo_ranging_unit.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // Item field widths.
  localparam int CMD_W  = 2;
  localparam int CHAN_W = 3;
  localparam int TS_W   = 32;
  localparam int MASK_W = 5;
  localparam int DIST_W = 16;

  // Commands carried in the input tuser field.
  typedef enum logic [CMD_W-1:0] {
    CMD_TRIGGER = 2'd0,
    CMD_ECHO    = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  // distance = 165000 * dt / 72000000 = 11 * dt / 4800 (truncating).
  // Any dt at or above SAT_TICKS gives more than 65535 mm.
  localparam logic [TS_W-1:0] SAT_TICKS = 32'd28597528;

  // Below SAT_TICKS, dt fits in DT_W bits and 11*dt/4800 equals
  // (dt * RECIP) >> RECIP_SHIFT exactly.
  localparam int DT_W        = 25;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP = 30'd629928537;

  localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

  // One result item.
  typedef struct packed {
    logic [MASK_W-1:0] armed_mask;
    logic [MASK_W-1:0] trigger_pulse;
    logic              measure_done;
    logic [DIST_W-1:0] distance;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/uer_dist_conv.sv =====
// Two-stage conversion of an echo pulse width in 72 MHz ticks to millimeters.
// Depends on uer_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps
`default_nettype none

module uer_dist_conv import uer_pkg::*; (
  input  logic              clk_i,
  input  logic [TS_W-1:0]   dt_i,
  output logic [DIST_W-1:0] dist_o
);

  localparam int PROD_W = DT_W + RECIP_W;

  logic [DT_W-1:0]   dt_q;
  logic              sat_q;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] dist_q;

  // The product by the reciprocal replaces the division by 4800/11.
  assign prod = PROD_W'(dt_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_i[DT_W-1:0];
    sat_q  <= (dt_i >= SAT_TICKS);
    dist_q <= sat_q ? DIST_MAX : prod[RECIP_SHIFT +: DIST_W];
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranging_unit.sv =====
// Top level of the multi-channel ultrasonic echo ranging unit.
// Depends on uer_pkg and uer_dist_conv.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one command item per clock cycle and returns exactly one
// result item for each, in order. A trigger item arms the channels in its
// mask, clears their stored distances and reports them as trigger pulses.
// An echo item samples one channel's echo level with a 72 MHz timestamp; a
// rising edge on an armed channel records the start time, and a falling edge
// on an armed channel disarms it and yields the distance in millimeters,
// saturated at 65535. A read item returns the stored distance of a channel.
// Each item passes through the pipeline stages before its result appears
// at the output: in the first the start-time memory data arrives and the
// pulse width is formed by a subtraction, in the second the 25 x 30 bit
// reciprocal multiply runs while the distance memory is read, and in the
// third the result is assembled and queued and, for a completed measurement,
// written to the distance memory. Both memories are read through a register,
// and a write followed at once by a read of the same channel is forwarded.
// Results wait in an eight-item output queue, so the input keeps
// taking items while results are stalled; s_axis_tready_o drops only when
// the queued plus in-flight items reach eight. With the output always ready
// the sustained rate is one item per cycle. No clearing pass is needed after
// reset: per-channel valid bits make unwritten entries read as zero.

module ultrasonic_echo_ranging_unit import uer_pkg::*; #(
  parameter int CHANNELS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: channel[2:0], level[3], timestamp[35:4], trigger_mask[40:36].
  input  logic [47:0] s_axis_tdata_i,
  // tuser: cmd[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  // Result items.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: distance[15:0], trigger_pulse[20:16], armed_mask[25:21].
  output logic [31:0] m_axis_tdata_o,
  // tuser: measure_done[0].
  output logic        m_axis_tuser_o
);

  localparam int AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW         = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
  localparam int FIFO_DEPTH = 8;
  localparam int FP_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FP_W + 1;

  // Input field unpacking.
  logic [CHAN_W-1:0] in_channel;
  logic              in_level;
  logic [TS_W-1:0]   in_timestamp;
  logic [MASK_W-1:0] in_tmask;
  logic              in_accept;

  assign in_channel   = s_axis_tdata_i[2:0];
  assign in_level     = s_axis_tdata_i[3];
  assign in_timestamp = s_axis_tdata_i[35:4];
  assign in_tmask     = s_axis_tdata_i[40:36];
  assign in_accept    = s_axis_tvalid_i && s_axis_tready_o;

  // Channel state kept in flip-flops.
  logic [CHANNELS-1:0] levels_q, levels_d;
  logic [CHANNELS-1:0] armed_q, armed_d;
  logic [CHANNELS-1:0] svalid_q;   // start time written since reset
  logic [CHANNELS-1:0] dvalid_q, dvalid_d;   // distance holds a value

  // ---------------------------------------------------------------------
  // Stage 1: start-time memory data arrives; levels and armed are updated.
  // ---------------------------------------------------------------------
  logic              s1_valid_q;
  cmd_e              s1_cmd_q;
  logic [CHAN_W-1:0] s1_ch_q;
  logic              s1_level_q;
  logic [TS_W-1:0]   s1_ts_q;
  logic [MASK_W-1:0] s1_tmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q   <= cmd_e'(s_axis_tuser_i);
      s1_ch_q    <= in_channel;
      s1_level_q <= in_level;
      s1_ts_q    <= in_timestamp;
      s1_tmask_q <= in_tmask;
    end
  end

  // Start-time memory with a one-entry forwarding register for the last write.
  logic [TS_W-1:0] st_mem [CHANNELS];
  logic [TS_W-1:0] st_rdata_q;
  logic            st_we;
  logic            sw_valid_q;
  logic [AW-1:0]   sw_idx_q;
  logic [TS_W-1:0] sw_data_q;

  logic [AW-1:0]       s1_idx;
  logic                s1_ok;
  logic [MW-1:0]       s1_tm_wide;
  logic [CHANNELS-1:0] s1_trig;
  logic                s1_was_high;
  logic                s1_is_armed;
  logic [TS_W-1:0]     s1_start;
  logic [TS_W-1:0]     s1_dt;
  logic                s1_done;
  logic [CHANNELS-1:0] s1_pulse;
  logic [MW-1:0]       s1_pulse_wide;
  logic [MW-1:0]       s1_armed_wide;

  assign s1_idx        = AW'(s1_ch_q);
  assign s1_ok         = (32'(s1_ch_q) < CHANNELS);
  assign s1_tm_wide    = MW'(s1_tmask_q);
  assign s1_trig       = s1_tm_wide[CHANNELS-1:0];
  assign s1_was_high   = levels_q[s1_idx];
  assign s1_is_armed   = armed_q[s1_idx];
  assign s1_start      = (sw_valid_q && (sw_idx_q == s1_idx)) ? sw_data_q :
                         (svalid_q[s1_idx] ? st_rdata_q : '0);
  assign s1_dt         = s1_ts_q - s1_start;
  assign s1_pulse_wide = MW'(s1_pulse);
  assign s1_armed_wide = MW'(armed_d);

  always_comb begin
    levels_d = levels_q;
    armed_d  = armed_q;
    st_we    = 1'b0;
    s1_done  = 1'b0;
    s1_pulse = '0;
    if (s1_valid_q) begin
      unique case (s1_cmd_q)
        CMD_TRIGGER: begin
          armed_d  = armed_q | s1_trig;
          s1_pulse = s1_trig;
        end
        CMD_ECHO: begin
          if (s1_ok) begin
            if (s1_level_q) begin
              st_we            = !s1_was_high && s1_is_armed;
              levels_d[s1_idx] = 1'b1;
            end else begin
              if (s1_was_high && s1_is_armed) begin
                armed_d[s1_idx] = 1'b0;
                s1_done         = 1'b1;
              end
              levels_d[s1_idx] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q   <= '0;
      armed_q    <= '0;
      svalid_q   <= '0;
      sw_valid_q <= 1'b0;
    end else begin
      levels_q   <= levels_d;
      armed_q    <= armed_d;
      sw_valid_q <= st_we;
      if (st_we) begin
        svalid_q[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[s1_idx] <= s1_ts_q;
    end
    st_rdata_q <= st_mem[AW'(in_channel)];
    sw_idx_q   <= s1_idx;
    sw_data_q  <= s1_ts_q;
  end

  // ---------------------------------------------------------------------
  // Stages 2 and 3: pulse width to millimeters; distance memory access.
  // ---------------------------------------------------------------------
  logic [DIST_W-1:0] conv_dist;

  uer_dist_conv u_dist_conv (
    .clk_i  (clk_i),
    .dt_i   (s1_dt),
    .dist_o (conv_dist)
  );

  logic                s2_valid_q, s3_valid_q;
  cmd_e                s2_cmd_q, s3_cmd_q;
  logic [AW-1:0]       s2_idx_q, s3_idx_q;
  logic                s2_ok_q, s3_ok_q;
  logic                s2_done_q, s3_done_q;
  logic [MASK_W-1:0]   s2_pulse_q, s3_pulse_q;
  logic [MASK_W-1:0]   s2_amask_q, s3_amask_q;
  logic [CHANNELS-1:0] s2_clr_q, s3_clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_cmd_q   <= s1_cmd_q;
    s2_idx_q   <= s1_idx;
    s2_ok_q    <= s1_ok;
    s2_done_q  <= s1_done;
    s2_pulse_q <= s1_pulse_wide[MASK_W-1:0];
    s2_amask_q <= s1_armed_wide[MASK_W-1:0];
    s2_clr_q   <= s1_pulse;
    s3_cmd_q   <= s2_cmd_q;
    s3_idx_q   <= s2_idx_q;
    s3_ok_q    <= s2_ok_q;
    s3_done_q  <= s2_done_q;
    s3_pulse_q <= s2_pulse_q;
    s3_amask_q <= s2_amask_q;
    s3_clr_q   <= s2_clr_q;
  end

  // Distance memory, read in stage 2 and written at the end of stage 3.
  logic [DIST_W-1:0] dist_mem [CHANNELS];
  logic [DIST_W-1:0] dm_rdata_q;
  logic              dm_we;
  logic              dw_valid_q;
  logic [AW-1:0]     dw_idx_q;
  logic [DIST_W-1:0] dw_data_q;
  logic [DIST_W-1:0] s3_stored;
  result_t           s3_result;

  assign dm_we     = s3_valid_q && s3_done_q;
  assign s3_stored = !dvalid_q[s3_idx_q] ? '0 :
                     ((dw_valid_q && (dw_idx_q == s3_idx_q)) ? dw_data_q : dm_rdata_q);

  always_comb begin
    dvalid_d = dvalid_q;
    if (s3_valid_q) begin
      dvalid_d = dvalid_q & ~s3_clr_q;
      if (s3_done_q) begin
        dvalid_d[s3_idx_q] = 1'b1;
      end
    end
  end

  always_comb begin
    s3_result.armed_mask    = s3_amask_q;
    s3_result.trigger_pulse = s3_pulse_q;
    s3_result.measure_done  = s3_done_q;
    if (s3_done_q) begin
      s3_result.distance = conv_dist;
    end else if ((s3_cmd_q == CMD_READ) && s3_ok_q) begin
      s3_result.distance = s3_stored;
    end else begin
      s3_result.distance = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q   <= '0;
      dw_valid_q <= 1'b0;
    end else begin
      dvalid_q   <= dvalid_d;
      dw_valid_q <= dm_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dist_mem[s3_idx_q] <= conv_dist;
    end
    dm_rdata_q <= dist_mem[s2_idx_q];
    dw_idx_q   <= s3_idx_q;
    dw_data_q  <= conv_dist;
  end

  // ---------------------------------------------------------------------
  // Output queue. Admission counts items still in the pipeline, so a push
  // always finds room.
  // ---------------------------------------------------------------------
  result_t          fifo_mem [FIFO_DEPTH];
  logic [FP_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fifo_cnt_q;
  logic [1:0]       inflight;
  logic [CNT_W-1:0] occupancy;
  logic             fifo_push, fifo_pop;
  result_t          head;

  assign inflight        = 2'(s1_valid_q) + 2'(s2_valid_q) + 2'(s3_valid_q);
  assign occupancy       = fifo_cnt_q + CNT_W'(inflight);
  assign s_axis_tready_o = (occupancy < CNT_W'(FIFO_DEPTH));
  assign fifo_push       = s3_valid_q;
  assign fifo_pop        = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_q + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_mem[wr_ptr_q] <= s3_result;
    end
  end

  assign head            = fifo_mem[rd_ptr_q];
  assign m_axis_tvalid_o = (fifo_cnt_q != '0);
  assign m_axis_tdata_o  = {6'd0, head.armed_mask, head.trigger_pulse, head.distance};
  assign m_axis_tuser_o  = head.measure_done;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_queue_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= CNT_W'(FIFO_DEPTH))
    else $error("output queue admitted more items than it can hold");

  a_done_is_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s3_done_q) |-> ((s3_cmd_q == CMD_ECHO) && s3_ok_q))
    else $error("measurement completed by an item that is not a valid echo");

  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_done_q) |-> !armed_q[s2_idx_q])
    else $error("channel still armed after a completed measurement");

  a_start_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |=> (svalid_q[sw_idx_q] && sw_valid_q))
    else $error("start time write not recorded for forwarding");

endmodule

`default_nettype wire

// ===== dv/tb_ultrasonic_echo_ranging_unit.sv =====
// Self-checking testbench for ultrasonic_echo_ranging_unit.
// Directed and random command items drive the input stream. Each result item
// is checked against an in-bench prediction of the ranging state. Uses uer_pkg.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranging_unit;
  import uer_pkg::*;

  localparam int          NUM_CH      = 5;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          RANDOM_ITEMS = 1350;
  localparam int          HOLD_CYCLES = 80;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [63:0] HALF_SOUND_MM_PER_S = 64'd165000;
  localparam logic [63:0] TICKS_PER_S = 64'd72000000;

  // One command item as the sender sees it.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [CHAN_W-1:0] chan;
    logic              lvl;
    logic [TS_W-1:0]   ts;
    logic [MASK_W-1:0] mask;
  } cmd_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  cmd_item_t in_item = '0;
  logic      out_ready = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  cmd_item_t cmd_items_q[$];
  result_t   expected_results_q[$];
  int        total_items;
  int        accepted_cnt = 0;
  int        error_cnt = 0;
  int        cycle_cnt = 0;
  logic      in_taken = 1'b0;

  // Receiver hold-off used to fill the unit's output queue once.
  logic hold_on = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;

  // Predicted ranging state.
  logic [NUM_CH-1:0] echo_lvl;
  logic [NUM_CH-1:0] armed_ch;
  logic [TS_W-1:0]   start_ts [NUM_CH];
  logic [DIST_W-1:0] dist_mm [NUM_CH];

  result_t got_res;
  result_t want_res;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ultrasonic_echo_ranging_unit #(
    .CHANNELS(NUM_CH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  ({7'b0, in_item.mask, in_item.ts, in_item.lvl, in_item.chan}),
    .s_axis_tuser_i  (in_item.cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Pulse width to millimeters; the tick difference wraps modulo 2^32.
  function automatic logic [DIST_W-1:0] echo_width_mm(input logic [TS_W-1:0] t_start,
                                                      input logic [TS_W-1:0] t_stop);
    logic [TS_W-1:0] width;
    logic [63:0]     mm;
    width = t_stop - t_start;
    mm = (HALF_SOUND_MM_PER_S * {32'b0, width}) / TICKS_PER_S;
    if (mm > 64'(DIST_MAX)) mm = 64'(DIST_MAX);
    return mm[DIST_W-1:0];
  endfunction

  // Applies one item to the predicted state and returns its result.
  function automatic result_t ranging_result(input cmd_item_t it);
    result_t           r;
    logic [NUM_CH-1:0] arm_bits;
    int                i;
    r = '0;
    case (it.cmd)
      CMD_TRIGGER: begin
        arm_bits = it.mask[NUM_CH-1:0];
        for (i = 0; i < NUM_CH; i++) begin
          if (arm_bits[i]) dist_mm[i] = '0;
        end
        armed_ch = armed_ch | arm_bits;
        r.trigger_pulse = MASK_W'(arm_bits);
      end
      CMD_ECHO: begin
        if (it.chan < NUM_CH) begin
          if (it.lvl) begin
            // Rising edge on an armed channel starts the pulse.
            if (!echo_lvl[it.chan] && armed_ch[it.chan]) start_ts[it.chan] = it.ts;
            echo_lvl[it.chan] = 1'b1;
          end else begin
            // Falling edge on an armed channel ends the measurement.
            if (echo_lvl[it.chan] && armed_ch[it.chan]) begin
              armed_ch[it.chan] = 1'b0;
              dist_mm[it.chan] = echo_width_mm(start_ts[it.chan], it.ts);
              r.distance = dist_mm[it.chan];
              r.measure_done = 1'b1;
            end
            echo_lvl[it.chan] = 1'b0;
          end
        end
      end
      CMD_READ: begin
        if (it.chan < NUM_CH) r.distance = dist_mm[it.chan];
      end
      default: begin
        // The unused command changes nothing.
      end
    endcase
    r.armed_mask = MASK_W'(armed_ch);
    return r;
  endfunction

  // Idle percentage for either side, by test phase.
  function automatic int idle_pct(input bit for_sender);
    if (accepted_cnt < total_items / 3) return for_sender ? 35 : 63;
    if (accepted_cnt < 2 * total_items / 3) return for_sender ? 63 : 35;
    return 0;
  endfunction

  task automatic push_item(input logic [1:0] cmd, input int chan, input logic lvl,
                           input logic [TS_W-1:0] ts, input logic [MASK_W-1:0] mask);
    cmd_item_t it;
    it.cmd  = cmd;
    it.chan = chan[CHAN_W-1:0];
    it.lvl  = lvl;
    it.ts   = ts;
    it.mask = mask;
    cmd_items_q.push_back(it);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_cnt++;
    end
  endtask

  // Sender: a new item is presented only when the slot is free.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (cmd_items_q.size() > 0 &&
          (hold_on || $urandom_range(99, 0) >= idle_pct(1'b1))) begin
        in_item  <= cmd_items_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accepted items update the prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && s_axis_tready_o;
      if (in_valid && s_axis_tready_o) begin
        expected_results_q.push_back(ranging_result(in_item));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // One long receiver stall halfway through, so the input backs up.
  always @(posedge clk_i) begin
    if (rst_ni && !hold_done && accepted_cnt >= total_items / 2) begin
      if (hold_cnt == HOLD_CYCLES) begin
        hold_on   <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_on  <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || hold_on) out_ready <= 1'b0;
    else out_ready <= $urandom_range(99, 0) >= idle_pct(1'b0);
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      got_res.distance      = m_axis_tdata_o[15:0];
      got_res.trigger_pulse = m_axis_tdata_o[20:16];
      got_res.armed_mask    = m_axis_tdata_o[25:21];
      got_res.measure_done  = m_axis_tuser_o;
      if (expected_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got_res);
        error_cnt++;
      end else begin
        want_res = expected_results_q.pop_front();
        check_field("distance", want_res.distance, got_res.distance);
        check_field("measure_done", want_res.measure_done, got_res.measure_done);
        check_field("trigger_pulse", want_res.trigger_pulse, got_res.trigger_pulse);
        check_field("armed_mask", want_res.armed_mask, got_res.armed_mask);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [TS_W-1:0]   now_ticks;
    logic [TS_W-1:0]   width;
    logic [MASK_W-1:0] burst_mask;
    int                first_ch;
    int                ch;
    int                k;
    int                sel;

    echo_lvl = '0;
    armed_ch = '0;
    for (k = 0; k < NUM_CH; k++) begin
      start_ts[k] = '0;
      dist_mm[k]  = '0;
    end

    // Directed: reset contents, out-of-range channels and the unused command.
    push_item(CMD_READ, 0, 1'b0, 32'h0, 5'h00);
    push_item(CMD_READ, 7, 1'b1, 32'hFFFF_FFFF, 5'h1F);
    push_item(CMD_UNUSED, 3, 1'b1, 32'hFFFF_FFFF, 5'h1F);
    push_item(CMD_TRIGGER, 0, 1'b0, 32'h0, 5'h1F);
    // Longest possible pulse saturates.
    push_item(CMD_ECHO, 0, 1'b1, 32'h0000_0000, 5'h00);
    push_item(CMD_ECHO, 0, 1'b0, 32'hFFFF_FFFF, 5'h00);
    // Timestamp wraps between the edges.
    push_item(CMD_ECHO, 1, 1'b1, 32'hFFFF_FF00, 5'h00);
    push_item(CMD_ECHO, 1, 1'b0, 32'h0000_0100, 5'h00);
    // A repeated high sample does not restart; pulse just below saturation.
    push_item(CMD_ECHO, 2, 1'b1, 32'd1000, 5'h00);
    push_item(CMD_ECHO, 2, 1'b1, 32'd5000, 5'h00);
    push_item(CMD_ECHO, 2, 1'b0, 32'd1000 + SAT_TICKS - 32'd1, 5'h00);
    // Low sample without a prior high completes nothing.
    push_item(CMD_ECHO, 3, 1'b0, 32'd77, 5'h1F);
    // Zero-width pulse.
    push_item(CMD_ECHO, 4, 1'b1, 32'h8000_0000, 5'h00);
    push_item(CMD_ECHO, 4, 1'b0, 32'h8000_0000, 5'h00);
    // Edges on channels past the last one are ignored.
    push_item(CMD_ECHO, 5, 1'b1, 32'h1234_5678, 5'h00);
    push_item(CMD_ECHO, 7, 1'b0, 32'hFFFF_FFFF, 5'h1F);
    // Channel 0 is now unarmed: edges only move the stored level.
    push_item(CMD_ECHO, 0, 1'b1, 32'd10, 5'h00);
    push_item(CMD_ECHO, 0, 1'b0, 32'd900000, 5'h00);
    push_item(CMD_READ, 0, 1'b0, 32'h0, 5'h00);
    push_item(CMD_READ, 2, 1'b0, 32'h0, 5'h00);
    push_item(CMD_READ, 1, 1'b0, 32'h0, 5'h00);
    // Empty trigger, then a full one that clears every stored distance.
    push_item(CMD_TRIGGER, 7, 1'b1, 32'hFFFF_FFFF, 5'h00);
    push_item(CMD_TRIGGER, 0, 1'b0, 32'h0, 5'h1F);
    push_item(CMD_READ, 0, 1'b0, 32'h0, 5'h00);

    // Random: mostly trigger-then-echo bursts with random timing, some noise.
    now_ticks = $urandom;
    while (cmd_items_q.size() < 24 + RANDOM_ITEMS) begin
      sel = $urandom_range(99, 0);
      if (sel < 15) begin
        push_item(2'($urandom_range(3, 0)), $urandom_range(7, 0),
                  1'($urandom_range(1, 0)), $urandom, 5'($urandom_range(31, 0)));
      end else begin
        burst_mask = 5'($urandom_range(31, 1));
        push_item(CMD_TRIGGER, $urandom_range(7, 0), 1'($urandom_range(1, 0)), $urandom,
                  burst_mask);
        first_ch = $urandom_range(NUM_CH - 1, 0);
        for (k = 0; k < NUM_CH; k++) begin
          ch = (first_ch + k) % NUM_CH;
          if (burst_mask[ch]) begin
            now_ticks = now_ticks + $urandom_range(5000, 0);
            push_item(CMD_ECHO, ch, 1'b1, now_ticks, 5'($urandom_range(31, 0)));
            width = ($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(2000000, 0);
            if ($urandom_range(9, 0) == 0)
              push_item(CMD_ECHO, ch, 1'b1, now_ticks + width / 2,
                        5'($urandom_range(31, 0)));
            now_ticks = now_ticks + width;
            // Now and then the echo never returns and the channel stays armed.
            if ($urandom_range(9, 0) != 0)
              push_item(CMD_ECHO, ch, 1'b0, now_ticks, 5'($urandom_range(31, 0)));
            if ($urandom_range(9, 0) < 3)
              push_item(CMD_READ, ch, 1'($urandom_range(1, 0)), $urandom,
                        5'($urandom_range(31, 0)));
          end
        end
      end
    end
    total_items = cmd_items_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_items_q.size() > 0 || in_valid || expected_results_q.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
